@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertions clocked on clk and disabled while arst_n is low.
`ifndef SYNTHESIS
`define MOR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MOR_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define MOR_ASSERT(label, prop, msg)
`define MOR_NEVER(label, expr, msg)
`endif

`endif

@@ src/mor_pkg.sv @@
package mor_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int HEIGHT_BITS = 16;
	localparam int COL_BITS    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CNT_W       = COL_BITS + 1;
	localparam int CFG_W       = 9;
	localparam int AREA_W      = 25;

	// queue depth must be a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_W-1:0]       ROW_WIDTH_RESET = CFG_W'(256);
	localparam logic [AREA_W-1:0]      AREA_MAX        = '1;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX      = '1;

	typedef struct packed {
		logic                cell_val;
		logic                last;
		logic                row_end;
		logic [COL_BITS-1:0] col;
	} mor_item_t;

	typedef struct packed {
		logic idle;
		logic stack_empty;
		logic result_pending;
	} mor_back_status_t;

endpackage

@@ src/maximal_ones_rectangle.sv @@
// channel | signals                          | dir | transfer when
// input   | in_valid/in_ready, cell_req,     | in  | in_valid && in_ready
//         | end_of_matrix                    |     |
// result  | out_valid/out_ready, max_area    | out | out_valid && out_ready
// config  | cfg_we, cfg_wdata (row width)    | in  | cfg_we
//
// A cell that does not close a row passes the back end through S_TAKE and S_UPD.
// Closing a row adds S_ERD, then a push per column (S_ECMP) and a pop per column (S_POPRD,
// S_POPEX), one more compare per pop taken before the row end, plus S_FIN and S_OUT on the last cell.
// The front takes cells while the two-entry queue has room; a held result
// does not stall the back end until the next matrix end.
// Reset clears the heights through per-column valid bits, no sweep.
`include "assert_macros.svh"

module maximal_ones_rectangle (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mor_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cell_req,
	input  logic                       end_of_matrix,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mor_pkg::AREA_W-1:0] max_area
);
	import mor_pkg::*;

	mor_item_t         f_item;
	logic              f_valid;
	logic              f_ready;
	mor_item_t         b_item;
	logic              b_valid;
	logic              b_ready;
	logic [QCNT_W-1:0] q_count;
	mor_back_status_t  b_status;

	mor_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cell_req      (cell_req),
		.end_of_matrix (end_of_matrix),
		.item_valid    (f_valid),
		.item_ready    (f_ready),
		.item          (f_item)
	);

	mor_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_item  (b_item),
		.count    (q_count)
	);

	mor_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_item    (b_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.max_area  (max_area),
		.status    (b_status)
	);

	`MOR_NEVER(a_queue_bound, q_count > QCNT_W'(QUEUE_DEPTH), "queue overfilled")
	`MOR_ASSERT(a_idle_flushed, b_status.idle |-> b_status.stack_empty, "stack not flushed")
	`MOR_ASSERT(a_result_flushed, $rose(out_valid) |-> $past(b_status.result_pending),
		"result without matrix end")

endmodule

@@ src/mor_front.sv @@
module mor_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mor_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cell_req,
	input  logic                       end_of_matrix,
	output logic                       item_valid,
	input  logic                       item_ready,
	output mor_pkg::mor_item_t         item
);
	import mor_pkg::*;

	localparam int WCMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

	logic [CFG_W-1:0]    row_width_q;
	logic [COL_BITS-1:0] col_q;
	logic [WCMP_W-1:0]   eff_w;
	logic [CNT_W-1:0]    col_next;
	logic                row_end;

	always_comb begin
		if (row_width_q == '0) begin
			eff_w = WCMP_W'(1);
		end else if (WCMP_W'(row_width_q) > WCMP_W'(MAX_COLUMNS)) begin
			eff_w = WCMP_W'(MAX_COLUMNS);
		end else begin
			eff_w = WCMP_W'(row_width_q);
		end
	end

	assign col_next = CNT_W'(col_q) + CNT_W'(1);
	assign row_end  = (WCMP_W'(col_next) >= eff_w) || end_of_matrix;

	assign item.cell_val = cell_req;
	assign item.last     = end_of_matrix;
	assign item.row_end  = row_end;
	assign item.col      = col_q;
	assign item_valid    = in_valid;
	assign in_ready      = item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
			col_q       <= '0;
		end else begin
			if (cfg_we) begin
				row_width_q <= cfg_wdata;
			end
			if (in_valid && item_ready) begin
				col_q <= row_end ? '0 : col_next[COL_BITS-1:0];
			end
		end
	end

endmodule

@@ src/mor_queue.sv @@
module mor_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_valid,
	output logic                       wr_ready,
	input  mor_pkg::mor_item_t         wr_item,
	output logic                       rd_valid,
	input  logic                       rd_ready,
	output mor_pkg::mor_item_t         rd_item,
	output logic [mor_pkg::QCNT_W-1:0] count
);
	import mor_pkg::*;

	mor_item_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = entry_q[rd_ptr_q];
	assign count    = count_q;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ src/mor_back.sv @@
module mor_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  mor_pkg::mor_item_t         q_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mor_pkg::AREA_W-1:0] max_area,
	output mor_pkg::mor_back_status_t  status
);
	import mor_pkg::*;

	localparam int PROD_W = HEIGHT_BITS + CNT_W;
	localparam int SAT_W  = (PROD_W > AREA_W) ? PROD_W : AREA_W;

	typedef enum logic [2:0] {
		S_TAKE,
		S_UPD,
		S_ERD,
		S_ECMP,
		S_POPRD,
		S_POPEX,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [COL_BITS-1:0]    idx;
		logic [HEIGHT_BITS-1:0] h;
	} stk_entry_t;

	state_t                 state_q;
	mor_item_t              item_q;
	logic [CNT_W-1:0]       cols_q;
	logic [CNT_W-1:0]       pos_q;
	logic [CNT_W-1:0]       depth_q;
	logic [COL_BITS-1:0]    top_idx_q;
	logic [HEIGHT_BITS-1:0] top_h_q;
	logic [HEIGHT_BITS-1:0] cur_h_q;
	logic                   use_cur_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   prod_v_q;
	logic [AREA_W-1:0]      best_q;
	logic                   out_valid_q;
	logic [AREA_W-1:0]      max_area_q;

	logic [HEIGHT_BITS-1:0] hmem [MAX_COLUMNS];
	logic [MAX_COLUMNS-1:0] hval_q;
	logic [HEIGHT_BITS-1:0] h_rd_q;
	logic                   hv_rd_q;
	stk_entry_t             stk_mem [MAX_COLUMNS];
	stk_entry_t             stk_rd_q;

	logic [HEIGHT_BITS-1:0] rd_h;
	logic [HEIGHT_BITS-1:0] h_cmp;
	logic [HEIGHT_BITS-1:0] upd_h;
	logic                   do_push;
	logic [CNT_W-1:0]       pos_inc;
	logic [CNT_W-1:0]       new_depth;
	logic [CNT_W-1:0]       span;
	logic [COL_BITS-1:0]    h_addr;
	logic [COL_BITS-1:0]    stk_waddr;
	logic [COL_BITS-1:0]    stk_raddr;
	logic [AREA_W-1:0]      sat_area;
	logic                   slot_free;

	assign rd_h      = hv_rd_q ? h_rd_q : '0;
	assign h_cmp     = use_cur_q ? cur_h_q : rd_h;
	assign do_push   = (depth_q == '0) || (top_h_q <= h_cmp);
	assign pos_inc   = pos_q + CNT_W'(1);
	assign new_depth = depth_q - CNT_W'(1);
	assign stk_waddr = COL_BITS'(depth_q - CNT_W'(1));
	assign stk_raddr = COL_BITS'(depth_q - CNT_W'(2));
	assign span      = (new_depth == '0) ? pos_q
	                   : (pos_q - CNT_W'(stk_rd_q.idx) - CNT_W'(1));
	assign upd_h     = !item_q.cell_val ? '0
	                   : ((rd_h == HEIGHT_MAX) ? rd_h : rd_h + HEIGHT_BITS'(1));
	assign sat_area  = (SAT_W'(prod_q) > SAT_W'(AREA_MAX)) ? AREA_MAX : AREA_W'(prod_q);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		unique case (state_q)
			S_TAKE:  h_addr = q_item.col;
			S_ERD:   h_addr = pos_q[COL_BITS-1:0];
			S_ECMP:  h_addr = pos_inc[COL_BITS-1:0];
			default: h_addr = item_q.col;
		endcase
	end

	assign q_ready               = (state_q == S_TAKE);
	assign out_valid             = out_valid_q;
	assign max_area              = max_area_q;
	assign status.idle           = (state_q == S_TAKE);
	assign status.stack_empty    = (depth_q == '0);
	assign status.result_pending = (state_q == S_OUT);

	always_ff @(posedge clk) begin
		h_rd_q  <= hmem[h_addr];
		hv_rd_q <= hval_q[h_addr];
		if (state_q == S_UPD) begin
			hmem[item_q.col] <= upd_h;
		end
	end

	always_ff @(posedge clk) begin
		stk_rd_q <= stk_mem[stk_raddr];
		if (state_q == S_ECMP && do_push && depth_q != '0) begin
			stk_mem[stk_waddr] <= '{idx: top_idx_q, h: top_h_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_TAKE;
			item_q      <= '0;
			cols_q      <= '0;
			pos_q       <= '0;
			depth_q     <= '0;
			top_idx_q   <= '0;
			top_h_q     <= '0;
			cur_h_q     <= '0;
			use_cur_q   <= 1'b0;
			prod_q      <= '0;
			prod_v_q    <= 1'b0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
			max_area_q  <= '0;
			hval_q      <= '0;
		end else begin
			prod_v_q <= (state_q == S_POPEX);
			if (prod_v_q && sat_area > best_q) begin
				best_q <= sat_area;
			end
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_TAKE: begin
					if (q_valid) begin
						item_q  <= q_item;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					hval_q[item_q.col] <= 1'b1;
					if (item_q.row_end) begin
						cols_q    <= CNT_W'(item_q.col) + CNT_W'(1);
						pos_q     <= '0;
						depth_q   <= '0;
						use_cur_q <= 1'b0;
						state_q   <= S_ERD;
					end else begin
						state_q <= S_TAKE;
					end
				end
				S_ERD: begin
					state_q <= S_ECMP;
				end
				S_ECMP: begin
					cur_h_q <= h_cmp;
					if (do_push) begin
						top_idx_q <= pos_q[COL_BITS-1:0];
						top_h_q   <= h_cmp;
						depth_q   <= depth_q + CNT_W'(1);
						pos_q     <= pos_inc;
						use_cur_q <= 1'b0;
						state_q   <= (pos_inc == cols_q) ? S_POPRD : S_ECMP;
					end else begin
						use_cur_q <= 1'b1;
						state_q   <= S_POPRD;
					end
				end
				S_POPRD: begin
					state_q <= S_POPEX;
				end
				S_POPEX: begin
					prod_q    <= top_h_q * span;
					top_idx_q <= stk_rd_q.idx;
					top_h_q   <= stk_rd_q.h;
					depth_q   <= new_depth;
					if (pos_q < cols_q) begin
						state_q <= S_ECMP;
					end else if (new_depth != '0) begin
						state_q <= S_POPRD;
					end else begin
						state_q <= item_q.last ? S_FIN : S_TAKE;
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						max_area_q  <= best_q;
						best_q      <= '0;
						hval_q      <= '0;
						state_q     <= S_TAKE;
					end
				end
				default: begin
					state_q <= S_TAKE;
				end
			endcase
		end
	end

endmodule

@@ sim/maximal_ones_rectangle_tb.sv @@
module maximal_ones_rectangle_tb;
	import mor_pkg::*;

	localparam int DRAIN_CYCLES = 4 * (3 * MAX_COLUMNS + 5);

	typedef struct packed {
		logic cell_val;
		logic last;
	} cell_xfer_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             cell_req = 1'b0;
	logic             end_of_matrix = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [AREA_W-1:0] max_area;

	cell_xfer_t        cell_q[$];
	logic [AREA_W-1:0] area_q[$];
	cell_xfer_t        drv_item;
	logic              in_taken = 1'b0;
	int                send_idle_pct = 26;
	int                recv_idle_pct = 86;
	int                err_count = 0;

	logic [CFG_W-1:0]       mdl_width;
	logic [HEIGHT_BITS-1:0] mdl_heights[MAX_COLUMNS];
	int                     mdl_pos;
	logic [AREA_W-1:0]      mdl_best;
	logic                   mdl_got;
	logic [AREA_W-1:0]      mdl_area;
	logic [AREA_W-1:0]      exp_area;

	maximal_ones_rectangle uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cell_req     (cell_req),
		.end_of_matrix(end_of_matrix),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.max_area     (max_area)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int clip_width(input logic [CFG_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_COLUMNS)
			return MAX_COLUMNS;
		return int'(w);
	endfunction

	// largest rectangle under the histogram of columns 0..cols-1
	task automatic scan_histogram(input int cols);
		int     stk[MAX_COLUMNS];
		int     depth;
		int     pos;
		int     top;
		longint span;
		longint a;
		depth = 0;
		pos = 0;
		while (pos < cols || depth != 0) begin
			if (pos < cols && (depth == 0 || mdl_heights[stk[depth-1]] <= mdl_heights[pos])) begin
				stk[depth] = pos;
				depth++;
				pos++;
			end else begin
				depth--;
				top = stk[depth];
				span = (depth == 0) ? pos : pos - stk[depth-1] - 1;
				a = longint'(mdl_heights[top]) * span;
				if (a > longint'(AREA_MAX))
					a = longint'(AREA_MAX);
				if (a > longint'(mdl_best))
					mdl_best = a[AREA_W-1:0];
			end
		end
	endtask

	task automatic rect_predict(input logic cell_v, input logic last,
			output logic got, output logic [AREA_W-1:0] area);
		int col;
		col = (mdl_pos >= MAX_COLUMNS) ? 0 : mdl_pos;
		if (cell_v) begin
			if (mdl_heights[col] != HEIGHT_MAX)
				mdl_heights[col] = mdl_heights[col] + 1'b1;
		end else begin
			mdl_heights[col] = '0;
		end
		col++;
		if (col >= clip_width(mdl_width) || last) begin
			scan_histogram(col);
			col = 0;
		end
		mdl_pos = col;
		got = last;
		area = mdl_best;
		if (last) begin
			for (int i = 0; i < MAX_COLUMNS; i++)
				mdl_heights[i] = '0;
			mdl_best = '0;
			mdl_pos = 0;
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (cell_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_item = cell_q.pop_front();
					in_valid <= 1'b1;
					cell_req <= drv_item.cell_val;
					end_of_matrix <= drv_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdl_width = ROW_WIDTH_RESET;
			for (int i = 0; i < MAX_COLUMNS; i++)
				mdl_heights[i] = '0;
			mdl_pos = 0;
			mdl_best = '0;
			in_taken <= 1'b0;
		end else begin
			if (cfg_we)
				mdl_width = cfg_wdata;
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				rect_predict(cell_req, end_of_matrix, mdl_got, mdl_area);
				if (mdl_got)
					area_q.insert(area_q.size(), mdl_area);
			end
			if (out_valid && out_ready) begin
				if (area_q.size() == 0) begin
					$error("max_area: no transfer expected, actual %0d", max_area);
					err_count++;
				end else begin
					exp_area = area_q.pop_front();
					if (max_area !== exp_area) begin
						$error("max_area: expected %0d, actual %0d", exp_area, max_area);
						err_count++;
					end
				end
			end
		end
	end

	task automatic push_cell(input logic cell_v, input logic last);
		cell_xfer_t c;
		c.cell_val = cell_v;
		c.last = last;
		cell_q.insert(cell_q.size(), c);
	endtask

	task automatic settle();
		while (cell_q.size() != 0 || in_valid)
			@(posedge clk);
		while (area_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_width(input logic [CFG_W-1:0] w);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_row(input int w, input logic [31:0] bits, input logic last);
		for (int i = 0; i < w; i++)
			push_cell(bits[i], last && i == w - 1);
	endtask

	task automatic add_matrix(input int w_eff, output int n);
		int kind;
		int dens;
		int rows;
		int total;
		kind = $urandom_range(9);
		case ($urandom_range(3))
			0: dens = 30;
			1: dens = 70;
			2: dens = 90;
			default: dens = 100;
		endcase
		rows = $urandom_range(1, (w_eff > 32) ? 2 : 8);
		total = rows * w_eff;
		if (kind == 9) begin
			n = $urandom_range(1, 20);
			for (int i = 0; i < n; i++)
				push_cell($urandom_range(1), $urandom_range(15) == 0);
		end else begin
			// broken matrices end early, mid-row or not
			if (kind >= 7)
				total = $urandom_range(1, total);
			n = total;
			for (int i = 0; i < total; i++)
				push_cell($urandom_range(99) < dens, i == total - 1);
		end
	endtask

	task automatic random_part(input int n_items);
		int sent;
		int grp;
		int k;
		logic [CFG_W-1:0] w;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(19))
				0: w = '0;
				1: w = CFG_W'(1);
				2: w = CFG_W'(MAX_COLUMNS);
				3: w = CFG_W'($urandom_range(MAX_COLUMNS + 1, (1 << CFG_W) - 1));
				4, 5, 6, 7: w = CFG_W'($urandom_range(9, 32));
				default: w = CFG_W'($urandom_range(2, 8));
			endcase
			set_width(w);
			grp = 0;
			while (grp < 60) begin
				add_matrix(clip_width(w), k);
				grp += k;
			end
			sent += grp;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset width, last cell in mid-row
		push_cell(1'b1, 1'b1);
		push_cell(1'b0, 1'b1);
		// zero width acts as one column
		set_width('0);
		push_cell(1'b1, 1'b0);
		push_cell(1'b1, 1'b0);
		push_cell(1'b1, 1'b1);
		set_width(CFG_W'(3));
		push_row(3, 32'b011, 1'b0);
		push_row(3, 32'b111, 1'b0);
		push_row(3, 32'b110, 1'b1);
		// width narrowed in mid-row
		push_row(2, 32'b11, 1'b0);
		set_width(CFG_W'(1));
		push_cell(1'b1, 1'b0);
		push_cell(1'b1, 1'b1);
		// oversized width saturates
		set_width('1);
		push_cell(1'b1, 1'b0);
		push_cell(1'b0, 1'b0);
		push_cell(1'b1, 1'b1);
		set_width(CFG_W'(MAX_COLUMNS));
		push_cell(1'b0, 1'b0);
		push_cell(1'b1, 1'b1);

		random_part(240);
		settle();
		send_idle_pct = 86;
		recv_idle_pct = 26;
		random_part(240);
		settle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_part(240);
		settle();

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#6000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/mor_pkg.sv
src/mor_front.sv
src/mor_queue.sv
src/mor_back.sv
src/maximal_ones_rectangle.sv
sim/maximal_ones_rectangle_tb.sv
